// ===== rtl/dbam_pkg.sv =====
// ----------------------------------------------------------------------------
// dbam_pkg: shared types and constants for the decimal add/multiply unit
// Item structs, command codes and digit sizes.
// ----------------------------------------------------------------------------
package dbam_pkg;
	localparam int DIGITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_ADD  = 2'd1,
		CMD_MUL  = 2'd2,
		CMD_RSV  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] digit_a;
		logic [3:0] digit_b;
	} in_item_t;

	typedef struct packed {
		logic [3:0] result_digit;
		logic       last_digit;
	} out_item_t;

	// operation handed from the front end to the engine
	typedef struct packed {
		logic is_mul;
	} op_t;
endpackage

// ===== rtl/dbam_front.sv =====
// ----------------------------------------------------------------------------
// dbam_front: operand loader
// Takes digit pairs into the operand memories and queues an operation when
// a finishing command arrives. Stalls from then until the engine signals done.
// ----------------------------------------------------------------------------
module dbam_front #(
	parameter int DIGITS = dbam_pkg::DIGITS_DEF,
	parameter int AW     = $clog2(DIGITS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dbam_pkg::in_item_t in_data,
	// operation queue (one slot)
	output logic              op_valid,
	output dbam_pkg::op_t     op,
	input  logic              op_take,
	// operand read ports driven by the engine
	input  logic [AW-1:0]     rd_a_addr,
	input  logic [AW-1:0]     rd_b_addr,
	output logic [3:0]        rd_a,
	output logic [3:0]        rd_b,
	input  logic              done
);
	import dbam_pkg::*;

	localparam int PW = $clog2(DIGITS + 1);

	logic [PW-1:0] pos_q;
	logic [DIGITS-1:0] av_q;  // valid bit per loaded position
	logic [3:0] mem_a [DIGITS];
	logic [3:0] mem_b [DIGITS];
	logic busy_q;
	logic op_valid_q;
	op_t op_q;
	logic acc;
	logic fin;
	logic [3:0] ra_q, rb_q;
	logic rva_q, rvb_q;

	assign in_stall = busy_q;
	assign acc = in_valid && !busy_q;
	assign fin = (in_data.cmd == CMD_ADD) || (in_data.cmd == CMD_MUL);
	assign op_valid = op_valid_q;
	assign op = op_q;

	// load position, valid bits, operation slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			av_q <= '0;
			busy_q <= 1'b0;
			op_valid_q <= 1'b0;
			op_q <= '0;
		end else begin
			if (acc) begin
				if (pos_q < PW'(DIGITS)) begin
					av_q[pos_q[AW-1:0]] <= 1'b1;
					pos_q <= pos_q + 1'b1;
				end
				if (fin) begin
					busy_q <= 1'b1;
					op_valid_q <= 1'b1;
					op_q.is_mul <= (in_data.cmd == CMD_MUL);
				end
			end
			if (op_take) op_valid_q <= 1'b0;
			if (done) begin
				busy_q <= 1'b0;
				pos_q <= '0;
				av_q <= '0;
			end
		end
	end

	// operand memories
	always_ff @(posedge clk) begin
		if (acc && pos_q < PW'(DIGITS)) begin
			mem_a[pos_q[AW-1:0]] <= in_data.digit_a;
			mem_b[pos_q[AW-1:0]] <= in_data.digit_b;
		end
		ra_q <= mem_a[rd_a_addr];
		rb_q <= mem_b[rd_b_addr];
		rva_q <= av_q[rd_a_addr];
		rvb_q <= av_q[rd_b_addr];
	end

	assign rd_a = rva_q ? ra_q : 4'd0;
	assign rd_b = rvb_q ? rb_q : 4'd0;
endmodule

// ===== rtl/dbam_engine.sv =====
// ----------------------------------------------------------------------------
// dbam_engine: decimal add / schoolbook multiply sequencer
// Walks digits with one digit sum or digit-times-digit product and decimal carry
// per ROW/CALC step, then streams the accumulator out, least significant first.
// ----------------------------------------------------------------------------
module dbam_engine #(
	parameter int DIGITS = dbam_pkg::DIGITS_DEF,
	parameter int AW     = $clog2(DIGITS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  dbam_pkg::op_t      op,
	output logic               op_take,
	output logic [AW-1:0]      rd_a_addr,
	output logic [AW-1:0]      rd_b_addr,
	input  logic [3:0]         rd_a,
	input  logic [3:0]         rd_b,
	output logic               done,
	output logic               out_valid,
	input  logic               out_stall,
	output dbam_pkg::out_item_t out_data
);
	import dbam_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ROW  = 5'b00010,  // issue reads for digit j of row i
		ST_CALC = 5'b00100,  // read data back, accumulate
		ST_OUT  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t st_q;
	logic is_mul_q;
	logic [AW-1:0] i_q, j_q, o_q;
	logic [6:0] carry_q;
	logic [3:0] acc [DIGITS];
	logic [3:0] acc_rd;
	logic [7:0] prod;
	logic [8:0] t;
	logic [16:0] tq;
	logic [3:0] tdig;
	logic [6:0] tcar;
	logic ov_q;
	out_item_t od_q;
	logic jlast;

	assign op_take = (st_q == ST_IDLE) && op_valid;
	assign done = (st_q == ST_DONE);
	// add: row 0 with B as addend; multiply: A[j-i] times B[i]
	assign rd_a_addr = is_mul_q ? AW'(j_q - i_q) : j_q;
	assign rd_b_addr = is_mul_q ? i_q : j_q;
	assign acc_rd = (is_mul_q && i_q != '0) ? acc[j_q] : 4'd0;
	assign prod = is_mul_q ? {4'd0, rd_a} * {4'd0, rd_b} : {4'd0, rd_a} + {4'd0, rd_b};
	assign t = {5'd0, acc_rd} + {1'b0, prod} + {2'd0, carry_q};
	// divide by ten via reciprocal multiply, exact for every value of the 9-bit t
	assign tq = 17'(t) * 17'd205;
	assign tcar = {1'b0, tq[16:11]};
	assign tdig = 4'(t - 9'(tcar) * 9'd10);
	assign jlast = (j_q == AW'(DIGITS - 1));
	assign out_valid = ov_q;
	assign out_data = od_q;

	always_ff @(posedge clk) begin
		if (st_q == ST_CALC) acc[j_q] <= tdig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			is_mul_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			o_q <= '0;
			carry_q <= '0;
			ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			if (ov_q && !out_stall && st_q != ST_OUT) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (op_valid) begin
						is_mul_q <= op.is_mul;
						i_q <= '0;
						j_q <= '0;
						carry_q <= '0;
						st_q <= ST_ROW;
					end
				end
				ST_ROW: st_q <= ST_CALC;
				ST_CALC: begin
					if (jlast) begin
						carry_q <= '0;
						if (!is_mul_q || i_q == AW'(DIGITS - 1)) begin
							o_q <= '0;
							st_q <= ST_OUT;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= i_q + 1'b1;
							st_q <= ST_ROW;
						end
					end else begin
						carry_q <= tcar;
						j_q <= j_q + 1'b1;
						st_q <= ST_ROW;
					end
				end
				ST_OUT: begin
					if (!ov_q || !out_stall) begin
						ov_q <= 1'b1;
						od_q.result_digit <= acc[o_q];
						od_q.last_digit <= (o_q == AW'(DIGITS - 1));
						o_q <= o_q + 1'b1;
						if (o_q == AW'(DIGITS - 1)) st_q <= ST_DONE;
					end
				end
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/decimal_bignum_add_multiply.sv =====
// After the finishing item the sequencer computes all digits; results then go
// one per cycle when not stalled. Loads are taken one item per cycle while
// not stalled; the operand loader stalls input from the finishing item until
// the sequencer reaches its done state after issuing the last result digit.
// Reset (arst_n, async low) clears positions, valid bits and the sequencer.
// ----------------------------------------------------------------------------
// decimal_bignum_add_multiply: fixed-width BCD adder and multiplier
// Operand loader feeding a digit-serial add/multiply sequencer.
// ----------------------------------------------------------------------------
module decimal_bignum_add_multiply #(
	parameter int DIGITS = dbam_pkg::DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dbam_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dbam_pkg::out_item_t out_data
);
	import dbam_pkg::*;

	localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic op_valid, op_take, done;
	op_t op;
	logic [AW-1:0] ra_addr, rb_addr;
	logic [3:0] ra, rb;

	dbam_front #(.DIGITS(DIGITS), .AW(AW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .op_valid(op_valid), .op(op), .op_take(op_take),
		.rd_a_addr(ra_addr), .rd_b_addr(rb_addr), .rd_a(ra), .rd_b(rb),
		.done(done)
	);

	dbam_engine #(.DIGITS(DIGITS), .AW(AW)) u_engine (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op(op),
		.op_take(op_take), .rd_a_addr(ra_addr), .rd_b_addr(rb_addr),
		.rd_a(ra), .rd_b(rb), .done(done), .out_valid(out_valid),
		.out_stall(out_stall), .out_data(out_data)
	);
endmodule

// ===== rtl/dbam_checker.sv =====
// ----------------------------------------------------------------------------
// dbam_checker: port-level checks for the decimal add/multiply unit
// Watches the top-level ports and flags protocol or range slips.
// ----------------------------------------------------------------------------
module dbam_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input dbam_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input dbam_pkg::out_item_t out_data
);
	import dbam_pkg::*;

	// every result digit is decimal
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.result_digit <= 4'd9) else $error("bad digit");

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// a finishing item stalls the input on the next cycle
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.cmd == CMD_ADD || in_data.cmd == CMD_MUL)
		|=> in_stall) else $error("no stall after finishing item");

	// no new result starts while the input is open
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid || !$past(in_stall) || $past(out_valid))
		else $error("result without operation");
endmodule

bind decimal_bignum_add_multiply dbam_checker u_dbam_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);
